### rtl/ckh_pkg.sv
// ----------------------------------------------------------------------------
// ckh_pkg
// Types and constants shared by the cuckoo hash table modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ckh_pkg;

    localparam int KEY_W  = 31;
    localparam int TS_W   = 11;
    localparam int SLOT_W = 10;
    localparam int STAT_W = 3;
    localparam int DCNT_W = 5;

    // entry word: valid bit over key
    localparam int ENTRY_W = KEY_W + 1;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STAT_W-1:0] ST_PRESENT   = 3'd1;
    localparam logic [STAT_W-1:0] ST_FOUND     = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd4;
    localparam logic [STAT_W-1:0] ST_CYCLE     = 3'd5;

    localparam logic [DCNT_W-1:0] DIV_LAST = 5'(KEY_W - 1);

    typedef struct packed {
        logic             opcode;
        logic [KEY_W-1:0] key;
    } in_item_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              which_table;
        logic [SLOT_W-1:0] slot;
        logic [KEY_W-1:0]  dropped_key;
    } out_item_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_KICK,
        S_HASH0,
        S_HASH1,
        S_READ,
        S_EVAL,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic              clear;
        logic              load;
        logic              div_start;
        logic              div_src;
        logic              save_p0;
        logic              save_p1;
        logic              rd;
        logic              step_write;
        logic              count_inc;
        logic              result;
        logic [STAT_W-1:0] code;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic div_done;
        logic op;
        logic in0;
        logic in1;
        logic full;
        logic moves_done;
        logic cur_valid;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

### rtl/cuckoo_hash_table.sv
// ----------------------------------------------------------------------------
// cuckoo_hash_table
// Two-table cuckoo hash with insert and lookup over 31-bit keys.
// ----------------------------------------------------------------------------
// usage
//   in channel: in_valid/in_ready carry an item {opcode, key}; insert or look up
//   out channel: out_valid/out_ready carry one result item per input item
//   cfg_we/cfg_wdata write table_size; only while the block is idle
//   sequence: each hash round is two serial divisions by the size, of the key
//   and then of its quotient, one quotient bit a cycle, plus a table read;
//   out_valid rises once the round and its evaluation finish and the result
//   is registered, and each displacement adds another round
//   one item is in work at a time; the next is taken after the last's result
//   reset: a clearing pass zeroes every table entry, in_ready
//   stays low until it finishes; configuration writes are taken meanwhile
//   a stalled receiver holds the result in the output register; the next item
//   may be taken and worked on, and its result waits until the register frees
// ----------------------------------------------------------------------------
`default_nettype none

module cuckoo_hash_table #(
    parameter int SLOTS = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic [ckh_pkg::TS_W-1:0] cfg_wdata,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire ckh_pkg::in_item_t        in_item,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output ckh_pkg::out_item_t            out_item
);

    import ckh_pkg::*;

    // command and status between controller and datapath
    cmd_t cmd;
    sts_t sts;

    // sequencing: clear, hash, read, decide, chain
    ckh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // divider, tables, counters, result register
    ckh_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_item   (in_item),
        .out_item  (out_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // an item is loaded only on an accepted handshake
    a_load_accept : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (in_valid && in_ready))
        else $error("item loaded without handshake");

    // a pending result is never overwritten
    a_result_free : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.result |-> sts.out_free)
        else $error("result register overwritten");

    // no displacement beyond the limit
    a_chain_limit : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step_write |-> !sts.moves_done)
        else $error("displacement past limit");

    // the count grows only when an empty slot is filled
    a_count_empty : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.count_inc |-> (cmd.step_write && !sts.cur_valid))
        else $error("count raised without filling an empty slot");

endmodule

`default_nettype wire

### rtl/ckh_ram.sv
// ----------------------------------------------------------------------------
// ckh_ram
// Simple dual-port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ckh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/ckh_dp.sv
// ----------------------------------------------------------------------------
// ckh_dp
// Datapath: size register, bit-serial divider, both key tables, counters
// and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ckh_dp #(
    parameter int SLOTS = 1024
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_we,
    input  wire logic [ckh_pkg::TS_W-1:0] cfg_wdata,
    input  wire ckh_pkg::in_item_t       in_item,
    output ckh_pkg::out_item_t           out_item,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    input  wire ckh_pkg::cmd_t           cmd,
    output ckh_pkg::sts_t                sts
);

    import ckh_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);

    logic [TS_W-1:0]    ts_reg;
    logic [TS_W-1:0]    m;
    logic [KEY_W-1:0]   key_reg;
    logic [KEY_W-1:0]   hand_reg;
    logic               op_reg;
    logic               tbl_reg;
    logic [TS_W-1:0]    moves_reg;
    logic [TS_W-1:0]    count_reg;
    logic [IDX_W-1:0]   p0_reg;
    logic [IDX_W-1:0]   p1_reg;
    logic [IDX_W-1:0]   clr_reg;
    logic [IDX_W-1:0]   pos;
    logic               busy_reg;
    logic               done_reg;
    logic [DCNT_W-1:0]  dcnt_reg;
    logic [TS_W-1:0]    rem_reg;
    logic [KEY_W-1:0]   dq_reg;
    logic [TS_W:0]      rem_shift;
    logic               ge;
    logic [ENTRY_W-1:0] rd0;
    logic [ENTRY_W-1:0] rd1;
    logic [ENTRY_W-1:0] wdata;
    logic [IDX_W-1:0]   waddr;
    logic               we0;
    logic               we1;
    logic               in0;
    logic               in1;
    logic [KEY_W-1:0]   evicted;
    logic               found_code;
    out_item_t          out_reg;
    logic               ov_reg;

    // effective size: zero reads as one, clipped to the table depth
    always_comb
    begin
        if (ts_reg == '0)
        begin
            m = TS_W'(1);
        end
        else if (32'(ts_reg) > SLOTS)
        begin
            m = TS_W'(SLOTS);
        end
        else
        begin
            m = ts_reg;
        end
    end

    // restoring divider, one quotient bit a cycle
    assign rem_shift = {rem_reg, dq_reg[KEY_W-1]};
    assign ge        = rem_shift >= {1'b0, m};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            dcnt_reg <= '0;
        end
        else if (cmd.div_start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            dcnt_reg <= '0;
        end
        else if (busy_reg)
        begin
            dcnt_reg <= dcnt_reg + DCNT_W'(1);
            if (dcnt_reg == DIV_LAST)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            rem_reg <= '0;
            dq_reg  <= cmd.div_src ? dq_reg : hand_reg;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? TS_W'(rem_shift - {1'b0, m}) : TS_W'(rem_shift);
            dq_reg  <= {dq_reg[KEY_W-2:0], ge};
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ts_reg    <= TS_W'(1024);
            count_reg <= '0;
            clr_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                ts_reg <= cfg_wdata;
            end
            if (cmd.count_inc)
            begin
                count_reg <= count_reg + TS_W'(1);
            end
            if (cmd.clear)
            begin
                clr_reg <= clr_reg + IDX_W'(1);
            end
            if (cmd.result)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    assign pos     = tbl_reg ? p1_reg : p0_reg;
    assign evicted = tbl_reg ? rd1[KEY_W-1:0] : rd0[KEY_W-1:0];

    // item registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg   <= in_item.key;
            hand_reg  <= in_item.key;
            op_reg    <= in_item.opcode;
            tbl_reg   <= 1'b0;
            moves_reg <= '0;
        end
        else if (cmd.step_write)
        begin
            hand_reg  <= evicted;
            tbl_reg   <= ~tbl_reg;
            moves_reg <= moves_reg + TS_W'(1);
        end
        if (cmd.save_p0)
        begin
            p0_reg <= IDX_W'(rem_reg);
        end
        if (cmd.save_p1)
        begin
            p1_reg <= IDX_W'(rem_reg);
        end
    end

    // table write port, shared by the clearing pass and the chain
    assign we0   = cmd.clear || (cmd.step_write && !tbl_reg);
    assign we1   = cmd.clear || (cmd.step_write && tbl_reg);
    assign waddr = cmd.clear ? clr_reg : pos;
    assign wdata = cmd.clear ? '0 : {1'b1, hand_reg};

    ckh_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_tab0 (
        .clk   (clk),
        .we    (we0),
        .waddr (waddr),
        .wdata (wdata),
        .re    (cmd.rd),
        .raddr (p0_reg),
        .rdata (rd0)
    );

    ckh_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_tab1 (
        .clk   (clk),
        .we    (we1),
        .waddr (waddr),
        .wdata (wdata),
        .re    (cmd.rd),
        .raddr (p1_reg),
        .rdata (rd1)
    );

    assign in0 = rd0[KEY_W] && (rd0[KEY_W-1:0] == key_reg);
    assign in1 = rd1[KEY_W] && (rd1[KEY_W-1:0] == key_reg);

    assign found_code = (cmd.code == ST_FOUND) || (cmd.code == ST_PRESENT);

    always_ff @(posedge clk)
    begin
        if (cmd.result)
        begin
            out_reg.status      <= cmd.code;
            out_reg.which_table <= found_code && !in0;
            out_reg.slot        <= found_code ? (in0 ? SLOT_W'(p0_reg) : SLOT_W'(p1_reg))
                                              : '0;
            out_reg.dropped_key <= (cmd.code == ST_CYCLE) ? hand_reg : '0;
        end
    end

    assign out_item  = out_reg;
    assign out_valid = ov_reg;

    always_comb
    begin
        sts.clear_last = clr_reg == IDX_W'(SLOTS - 1);
        sts.div_done   = done_reg;
        sts.op         = op_reg;
        sts.in0        = in0;
        sts.in1        = in1;
        sts.full       = count_reg >= m;
        sts.moves_done = moves_reg >= m;
        sts.cur_valid  = tbl_reg ? rd1[KEY_W] : rd0[KEY_W];
        sts.out_free   = !ov_reg || out_ready;
    end

endmodule

`default_nettype wire

### rtl/ckh_ctrl.sv
// ----------------------------------------------------------------------------
// ckh_ctrl
// Controller: clearing pass, hash sequencing and the displacement chain.
// ----------------------------------------------------------------------------
`default_nettype none

module ckh_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire ckh_pkg::sts_t sts,
    output ckh_pkg::cmd_t      cmd
);

    import ckh_pkg::*;

    state_t            state_reg;
    state_t            state_next;
    logic              chain_reg;
    logic              chain_next;
    logic [STAT_W-1:0] code_reg;
    logic [STAT_W-1:0] code_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            chain_reg <= 1'b0;
            code_reg  <= ST_INSERTED;
        end
        else
        begin
            state_reg <= state_next;
            chain_reg <= chain_next;
            code_reg  <= code_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        chain_next = chain_reg;
        code_next  = code_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.code   = code_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    chain_next = 1'b0;
                    state_next = S_KICK;
                end
            end
            S_KICK:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_HASH0;
            end
            S_HASH0:
            begin
                if (sts.div_done)
                begin
                    cmd.save_p0   = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_src   = 1'b1;
                    state_next    = S_HASH1;
                end
            end
            S_HASH1:
            begin
                if (sts.div_done)
                begin
                    cmd.save_p1 = 1'b1;
                    state_next  = S_READ;
                end
            end
            S_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                state_next = S_RESULT;
                if (!chain_reg && sts.op == OP_LOOKUP)
                begin
                    code_next = (sts.in0 || sts.in1) ? ST_FOUND : ST_NOT_FOUND;
                end
                else if (!chain_reg && sts.full)
                begin
                    code_next = ST_FULL;
                end
                else if (!chain_reg && (sts.in0 || sts.in1))
                begin
                    code_next = ST_PRESENT;
                end
                else if (sts.moves_done)
                begin
                    code_next = ST_CYCLE;
                end
                else if (!sts.cur_valid)
                begin
                    cmd.step_write = 1'b1;
                    cmd.count_inc  = 1'b1;
                    code_next      = ST_INSERTED;
                end
                else
                begin
                    // evict and carry the old key to the other table
                    cmd.step_write = 1'b1;
                    chain_next     = 1'b1;
                    state_next     = S_KICK;
                end
            end
            S_RESULT:
            begin
                if (sts.out_free)
                begin
                    cmd.result = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### test/cuckoo_hash_table_test.sv
// ----------------------------------------------------------------------------
// cuckoo_hash_table_test
// Self-checking bench for the two-table cuckoo hash: a short directed table,
// then random inserts and lookups over a ladder of table sizes, with random
// gaps on the input side and random stalls on the output side. Every result
// item is compared field by field against its typed row or a behavioural copy of the table.
// ----------------------------------------------------------------------------
`default_nettype none

module cuckoo_hash_table_test;

    import ckh_pkg::*;

    localparam int SLOTS       = 1024;
    localparam int MAX_CYCLES  = 40000000;
    localparam int PHASE_ITEMS = 68;
    localparam int N_DIRECTED  = 11;
    localparam int N_SIZES     = 14;

    typedef struct packed {
        in_item_t  item;
        logic      typed;
        out_item_t result;
    } row_t;

    // directed rows at the reset size of 1024; typed results are easy to read off
    localparam row_t DIRECTED [N_DIRECTED] = '{
        '{'{OP_LOOKUP, 31'd0},          1'b1, '{ST_NOT_FOUND, 1'b0, 10'd0,    31'd0}},
        '{'{OP_INSERT, 31'd0},          1'b1, '{ST_INSERTED,  1'b0, 10'd0,    31'd0}},
        '{'{OP_INSERT, 31'd0},          1'b1, '{ST_PRESENT,   1'b0, 10'd0,    31'd0}},
        '{'{OP_LOOKUP, 31'h7fffffff},   1'b1, '{ST_NOT_FOUND, 1'b0, 10'd0,    31'd0}},
        '{'{OP_INSERT, 31'h7fffffff},   1'b1, '{ST_INSERTED,  1'b0, 10'd0,    31'd0}},
        '{'{OP_LOOKUP, 31'h7fffffff},   1'b1, '{ST_FOUND,     1'b0, 10'd1023, 31'd0}},
        '{'{OP_INSERT, 31'd1024},       1'b1, '{ST_INSERTED,  1'b0, 10'd0,    31'd0}},
        '{'{OP_LOOKUP, 31'd0},          1'b1, '{ST_FOUND,     1'b1, 10'd0,    31'd0}},
        '{'{OP_INSERT, 31'd0},          1'b1, '{ST_PRESENT,   1'b1, 10'd0,    31'd0}},
        '{'{OP_LOOKUP, 31'd1024},       1'b1, '{ST_FOUND,     1'b0, 10'd0,    31'd0}},
        '{'{OP_LOOKUP, 31'd2048},       1'b0, '0}
    };

    // size ladder: small sizes for deep chains and cycles, then the extremes;
    // stored count only grows, so the tiny sizes at the end mostly see full
    localparam logic [TS_W-1:0] SIZES [N_SIZES] = '{
        11'd4, 11'd5, 11'd6, 11'd8, 11'd12, 11'd16, 11'd24, 11'd32,
        11'd1024, 11'd2047, 11'd0, 11'd1, 11'd2, 11'd3
    };

    logic            clk;
    logic            rst_n;
    logic            cfg_we;
    logic [TS_W-1:0] cfg_wdata;
    logic            in_valid;
    logic            in_ready;
    in_item_t        in_item;
    logic            out_valid;
    logic            out_ready;
    out_item_t       out_item;

    cuckoo_hash_table #(
        .SLOTS (SLOTS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    // shadow copy of the hash tables
    logic [KEY_W-1:0] shadow_keys0 [SLOTS];
    logic             shadow_valid0 [SLOTS];
    logic [KEY_W-1:0] shadow_keys1 [SLOTS];
    logic             shadow_valid1 [SLOTS];
    logic [TS_W-1:0]  shadow_count;
    logic [TS_W-1:0]  shadow_size;

    out_item_t        pending_results [$];
    logic [KEY_W-1:0] recent_keys [$];

    int  mismatches;
    int  cycle_count;
    int  results_seen;
    int  status_tally [6];
    bit  burst_in;
    bit  burst_out;

    // ------------------------------------------------------------------------
    // clock and cycle limit
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // behavioural table: works out the result item and updates the shadow
    // ------------------------------------------------------------------------
    function automatic out_item_t hash_table_result(in_item_t it);
        int unsigned      m;
        int unsigned      p0;
        int unsigned      p1;
        int unsigned      pos;
        int unsigned      moves;
        logic [KEY_W-1:0] hand;
        logic [KEY_W-1:0] evicted;
        logic             tbl;
        logic             in0;
        logic             in1;
        out_item_t        r;
        r = '0;
        m = shadow_size;
        if (m == 0)
            m = 1;
        if (m > SLOTS)
            m = SLOTS;
        p0  = it.key % m;
        p1  = (it.key / m) % m;
        in0 = shadow_valid0[p0] && shadow_keys0[p0] == it.key;
        in1 = shadow_valid1[p1] && shadow_keys1[p1] == it.key;
        if (it.opcode == OP_LOOKUP)
        begin
            if (in0)
                r = '{ST_FOUND, 1'b0, SLOT_W'(p0), '0};
            else if (in1)
                r = '{ST_FOUND, 1'b1, SLOT_W'(p1), '0};
            else
                r.status = ST_NOT_FOUND;
        end
        else if (shadow_count >= m)
            r.status = ST_FULL;
        else if (in0)
            r = '{ST_PRESENT, 1'b0, SLOT_W'(p0), '0};
        else if (in1)
            r = '{ST_PRESENT, 1'b1, SLOT_W'(p1), '0};
        else
        begin
            // displacement chain, alternating tables
            hand  = it.key;
            tbl   = 1'b0;
            moves = 0;
            forever
            begin
                if (moves >= m)
                begin
                    r.status      = ST_CYCLE;
                    r.dropped_key = hand;
                    break;
                end
                pos = tbl ? (hand / m) % m : hand % m;
                if (!tbl && !shadow_valid0[pos])
                begin
                    shadow_keys0[pos]  = hand;
                    shadow_valid0[pos] = 1'b1;
                    shadow_count       = shadow_count + 1'b1;
                    break;
                end
                if (tbl && !shadow_valid1[pos])
                begin
                    shadow_keys1[pos]  = hand;
                    shadow_valid1[pos] = 1'b1;
                    shadow_count       = shadow_count + 1'b1;
                    break;
                end
                if (tbl)
                begin
                    evicted           = shadow_keys1[pos];
                    shadow_keys1[pos] = hand;
                end
                else
                begin
                    evicted           = shadow_keys0[pos];
                    shadow_keys0[pos] = hand;
                end
                hand  = evicted;
                tbl   = ~tbl;
                moves = moves + 1;
            end
            r.status = (r.status == ST_CYCLE) ? ST_CYCLE : ST_INSERTED;
        end
        status_tally[r.status] = status_tally[r.status] + 1;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // input side: random gap, then hold the item until it is taken
    // ------------------------------------------------------------------------
    task automatic send_item(in_item_t it, bit typed, out_item_t typed_result);
        int        gap;
        out_item_t predicted;
        gap = burst_in ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = hash_table_result(it);
        pending_results.push_back(typed ? typed_result : predicted);
        if (it.opcode == OP_INSERT)
        begin
            recent_keys.push_back(it.key);
            if (recent_keys.size() > 64)
                void'(recent_keys.pop_front());
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_size(logic [TS_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we      <= 1'b0;
        shadow_size  = value;
    endtask

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        in_item_t    it;
        int unsigned m;
        int unsigned pick;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        in_valid     = 1'b0;
        in_item      = '0;
        shadow_count = '0;
        shadow_size  = TS_W'(1024);
        burst_in     = 1'b0;
        mismatches   = 0;
        cycle_count  = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            shadow_valid0[i] = 1'b0;
            shadow_valid1[i] = 1'b0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++)
            send_item(DIRECTED[i].item, DIRECTED[i].typed, DIRECTED[i].result);
        drain_results();

        for (int ph = 0; ph < N_SIZES; ph++)
        begin
            write_size(SIZES[ph]);
            m = SIZES[ph];
            if (m == 0)
                m = 1;
            if (m > SLOTS)
                m = SLOTS;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // bursts with no gaps now and then
                if (n % 20 == 0)
                    burst_in = ($urandom_range(0, 3) == 0);
                it.opcode = ($urandom_range(0, 9) < 3) ? OP_LOOKUP : OP_INSERT;
                pick      = $urandom_range(0, 9);
                if (pick < 7)
                    it.key = KEY_W'($urandom_range(0, 2 * m * m - 1));
                else if (pick < 8 && recent_keys.size() != 0)
                    it.key = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
                else
                    it.key = KEY_W'($urandom);
                send_item(it, 1'b0, '0);
            end
            drain_results();
        end

        repeat (200) @(posedge clk);
        $display("covered %0d table sizes plus reset size; %0d results checked",
                 N_SIZES, results_seen);
        $display("inserted %0d, present %0d, found %0d, missing %0d, full %0d, cycle %0d",
                 status_tally[ST_INSERTED], status_tally[ST_PRESENT],
                 status_tally[ST_FOUND], status_tally[ST_NOT_FOUND],
                 status_tally[ST_FULL], status_tally[ST_CYCLE]);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // output side: random stall, then take and check one result item
    // ------------------------------------------------------------------------
    initial
    begin
        int        stall;
        out_item_t want;
        out_ready    = 1'b0;
        results_seen = 0;
        burst_out    = 1'b0;
        forever
        begin
            if (results_seen % 25 == 0)
                burst_out = ($urandom_range(0, 3) == 0);
            stall = burst_out ? 0 : $urandom_range(0, 8);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            results_seen = results_seen + 1;
            if (pending_results.size() == 0)
            begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display("unexpected result item %p", out_item);
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_item.status !== want.status
                    || out_item.which_table !== want.which_table
                    || out_item.slot !== want.slot
                    || out_item.dropped_key !== want.dropped_key)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("result %0d mismatch: expected %p, got %p",
                                 results_seen, want, out_item);
                end
            end
        end
    end

endmodule

`default_nettype wire
